// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check that expr holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("invariant violated");
// Check that cons holds in the same cycle whenever ante holds.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication violated");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/hms_pkg.sv =====
// ----------------------------------------------------------------------------
// hms_pkg
// Shared constants and types of the 3x3 heightmap smoothing filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hms_pkg;

    localparam int MAX_SIZE    = 1024;
    localparam int ADDR_W      = $clog2(MAX_SIZE);
    localparam int SIZE_W      = 11;
    localparam int SAMPLE_W    = 8;
    localparam int COORD_W     = 10;
    localparam int HEIGHT_W    = 11;
    localparam int SUM_W       = 13;
    localparam int LINE_W      = 2 * SAMPLE_W;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd256;
    localparam logic [SIZE_W-1:0] MIN_SIZE   = 11'd3;

    // floor(2*sum/5) = (sum * 26216) >> 16, exact for sum below 8192
    localparam int RECIP_W     = 15;
    localparam int RECIP_SHIFT = 16;
    localparam logic [RECIP_W-1:0] RECIP = 15'd26216;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    // position tag that travels with a sample down the pipeline
    typedef struct packed {
        logic               emit;
        logic               last;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } t_tag;

    typedef struct packed {
        logic [HEIGHT_W-1:0] height;
        logic [COORD_W-1:0]  col;
        logic [COORD_W-1:0]  row;
        logic                frame_end;
    } t_result;

    // one window column: [0] two rows up, [1] one row up, [2] current row
    typedef logic [2:0][SAMPLE_W-1:0] t_column;

endpackage

// ===== hw/rtl/heightmap_smooth_3x3.sv =====
// ----------------------------------------------------------------------------
// heightmap_smooth_3x3
// Throughput: one sample per cycle while the queue has room, bounded by the
// line buffer RAM, which takes one read and one write each cycle.
// Reset: clears counters, queue and size (256); line buffers keep contents.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

// Streaming 3x3 smoothing of a square heightmap given in raster order.
//
// Pipeline:
//   accept  : issue the line buffer read at the current column, latch the
//             sample and its position tag.
//   stage 1 : read data arrives; write back {row above, new sample} to the
//             same column, push the new column into the window, form the
//             weighted sum (1 2 1 / 2 8 2 / 1 2 1).
//   stage 2 : scale by 2/5 with a reciprocal multiply, push into the queue.
//
// A column is read again only one image width (at least 3 items) later, and
// its write back lands in the cycle after its read, so read and write of the
// same entry never overlap and no forwarding is needed.
//
// Ready is credit based: the queue must have room for every item still in
// the pipeline, so a stalled consumer never loses a result while the
// producer keeps streaming until the queue fills.
module heightmap_smooth_3x3 (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [hms_pkg::SIZE_W-1:0]      i_cfg_data,
    // sample input
    input  logic                            i_sample_valid,
    output logic                            o_sample_ready,
    input  logic [hms_pkg::SAMPLE_W-1:0]    i_sample,
    // result output
    output logic                            o_result_valid,
    input  logic                            i_result_ready,
    output logic [hms_pkg::HEIGHT_W-1:0]    o_height,
    output logic [hms_pkg::COORD_W-1:0]     o_col,
    output logic [hms_pkg::COORD_W-1:0]     o_row,
    output logic                            o_frame_end
);

    logic                               cfg_write;
    logic                               accept;
    logic [hms_pkg::ADDR_W-1:0]         r_size_m1;
    logic [hms_pkg::ADDR_W-1:0]         n_size_m1;
    logic [hms_pkg::COORD_W-1:0]        r_col;
    logic [hms_pkg::COORD_W-1:0]        r_row;
    logic [hms_pkg::COORD_W-1:0]        n_col;
    logic [hms_pkg::COORD_W-1:0]        n_row;
    hms_pkg::t_tag                      n_tag;

    // stage 1 registers
    logic                               r_v1;
    hms_pkg::t_tag                      r_tag1;
    logic [hms_pkg::SAMPLE_W-1:0]       r_sample1;
    logic [hms_pkg::ADDR_W-1:0]         r_addr1;

    logic [hms_pkg::LINE_W-1:0]         rd_data;
    hms_pkg::t_column                   column;
    logic                               stage2_valid;
    logic                               push;
    hms_pkg::t_result                   push_data;
    hms_pkg::t_result                   out_data;
    logic [hms_pkg::FIFO_CNT_W-1:0]     fifo_count;
    logic [hms_pkg::FIFO_CNT_W-1:0]     occupancy;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    // clamp the written size into range and keep size-1
    always_comb begin
        if (i_cfg_data < hms_pkg::MIN_SIZE) begin
            n_size_m1 = hms_pkg::ADDR_W'(hms_pkg::MIN_SIZE - 1'b1);
        end else if (i_cfg_data > hms_pkg::SIZE_W'(hms_pkg::MAX_SIZE)) begin
            n_size_m1 = hms_pkg::ADDR_W'(hms_pkg::MAX_SIZE - 1);
        end else begin
            n_size_m1 = hms_pkg::ADDR_W'(i_cfg_data - 1'b1);
        end
    end

    // hold a slot in the queue for each item in flight
    assign occupancy = fifo_count
                     + hms_pkg::FIFO_CNT_W'(r_v1)
                     + hms_pkg::FIFO_CNT_W'(stage2_valid);
    assign o_sample_ready = (occupancy < hms_pkg::FIFO_CNT_W'(hms_pkg::FIFO_DEPTH));
    assign accept         = i_sample_valid && o_sample_ready;

    // advance the raster position; wrap at the end of a line and of a frame
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (r_col == r_size_m1) begin
                n_col = '0;
                n_row = (r_row == r_size_m1) ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    // results belong to the position one up and one left of the new sample
    always_comb begin
        n_tag.emit = (r_row >= hms_pkg::COORD_W'(2)) && (r_col >= hms_pkg::COORD_W'(2));
        n_tag.last = (r_row == r_size_m1) && (r_col == r_size_m1);
        n_tag.col  = r_col - 1'b1;
        n_tag.row  = r_row - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_m1 <= hms_pkg::ADDR_W'(hms_pkg::SIZE_RESET - 1'b1);
            r_col     <= '0;
            r_row     <= '0;
            r_v1      <= 1'b0;
        end else begin
            r_v1 <= accept;
            if (cfg_write) begin
                // a size write restarts the image
                r_size_m1 <= n_size_m1;
                r_col     <= '0;
                r_row     <= '0;
            end else begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tag1    <= n_tag;
            r_sample1 <= i_sample;
            r_addr1   <= r_col;
        end
    end

    hms_line_buf u_line_buf (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (r_col),
        .o_rd_data (rd_data),
        .i_wr_en   (r_v1),
        .i_wr_addr (r_addr1),
        .i_wr_data ({rd_data[hms_pkg::SAMPLE_W-1:0], r_sample1})
    );

    // rd_data: upper byte two rows up, lower byte one row up
    assign column[0] = rd_data[hms_pkg::LINE_W-1:hms_pkg::SAMPLE_W];
    assign column[1] = rd_data[hms_pkg::SAMPLE_W-1:0];
    assign column[2] = r_sample1;

    hms_filter u_filter (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (r_v1),
        .i_column      (column),
        .i_tag         (r_tag1),
        .o_stage_valid (stage2_valid),
        .o_push        (push),
        .o_result      (push_data)
    );

    hms_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_valid (o_result_valid),
        .i_ready (i_result_ready),
        .o_data  (out_data),
        .o_count (fifo_count)
    );

    assign o_height    = out_data.height;
    assign o_col       = out_data.col;
    assign o_row       = out_data.row;
    assign o_frame_end = out_data.frame_end;

    // credits never overcommit the queue
    `ASSERT_ALWAYS(a_credit_bound, i_clk, i_rst_n, occupancy <= hms_pkg::FIFO_CNT_W'(hms_pkg::FIFO_DEPTH))
    // raster position stays inside the image
    `ASSERT_ALWAYS(a_pos_in_image, i_clk, i_rst_n, (r_col <= r_size_m1) && (r_row <= r_size_m1))
    // the last interior result sits on the diagonal corner
    `ASSERT_IMPLIES(a_frame_end_corner, i_clk, i_rst_n, o_result_valid && o_frame_end, o_row == o_col)

endmodule

// ===== hw/rtl/hms_out_fifo.sv =====
// ----------------------------------------------------------------------------
// hms_out_fifo
// Small result queue that decouples the filter pipeline from the consumer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hms_out_fifo (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  hms_pkg::t_result                i_data,
    output logic                            o_valid,
    input  logic                            i_ready,
    output hms_pkg::t_result                o_data,
    output logic [hms_pkg::FIFO_CNT_W-1:0]  o_count
);

    hms_pkg::t_result                 r_mem [hms_pkg::FIFO_DEPTH];
    logic [hms_pkg::FIFO_PTR_W-1:0]   r_wr_ptr;
    logic [hms_pkg::FIFO_PTR_W-1:0]   r_rd_ptr;
    logic [hms_pkg::FIFO_CNT_W-1:0]   r_count;
    logic [hms_pkg::FIFO_CNT_W-1:0]   n_count;
    logic                             pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_count = r_count;
        if (i_push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== hw/rtl/hms_line_buf.sv =====
// ----------------------------------------------------------------------------
// hms_line_buf
// Line buffer RAM: one entry per column, holding the two rows above.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hms_line_buf (
    input  logic                          i_clk,
    input  logic                          i_rd_en,
    input  logic [hms_pkg::ADDR_W-1:0]    i_rd_addr,
    output logic [hms_pkg::LINE_W-1:0]    o_rd_data,
    input  logic                          i_wr_en,
    input  logic [hms_pkg::ADDR_W-1:0]    i_wr_addr,
    input  logic [hms_pkg::LINE_W-1:0]    i_wr_data
);

    logic [hms_pkg::LINE_W-1:0] r_mem [hms_pkg::MAX_SIZE];
    logic [hms_pkg::LINE_W-1:0] r_rd_data;

    assign o_rd_data = r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// ===== hw/rtl/hms_filter.sv =====
// ----------------------------------------------------------------------------
// hms_filter
// 3x3 window, weighted sum and scale by 2/5 via reciprocal multiply.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hms_filter (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  hms_pkg::t_column     i_column,
    input  hms_pkg::t_tag        i_tag,
    output logic                 o_stage_valid,
    output logic                 o_push,
    output hms_pkg::t_result     o_result
);

    // two older window columns; the incoming one completes the window
    hms_pkg::t_column                   r_col0;
    hms_pkg::t_column                   r_col1;
    logic                               r_v2;
    hms_pkg::t_tag                      r_tag2;
    logic [hms_pkg::SUM_W-1:0]          r_sum;
    logic [hms_pkg::SUM_W-1:0]          n_sum;
    logic [hms_pkg::SUM_W+hms_pkg::RECIP_W-1:0] product;

    always_comb begin
        n_sum = hms_pkg::SUM_W'(r_col0[0])
              + (hms_pkg::SUM_W'(r_col1[0]) << 1)
              + hms_pkg::SUM_W'(i_column[0])
              + (hms_pkg::SUM_W'(r_col0[1]) << 1)
              + (hms_pkg::SUM_W'(r_col1[1]) << 3)
              + (hms_pkg::SUM_W'(i_column[1]) << 1)
              + hms_pkg::SUM_W'(r_col0[2])
              + (hms_pkg::SUM_W'(r_col1[2]) << 1)
              + hms_pkg::SUM_W'(i_column[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= i_valid;
        end
    end

    // slide the window and hold the sum for the scaling stage
    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_col0 <= r_col1;
            r_col1 <= i_column;
            r_sum  <= n_sum;
            r_tag2 <= i_tag;
        end
    end

    assign product  = r_sum * hms_pkg::RECIP;

    assign o_stage_valid      = r_v2;
    assign o_push             = r_v2 && r_tag2.emit;
    assign o_result.height    = product[hms_pkg::RECIP_SHIFT +: hms_pkg::HEIGHT_W];
    assign o_result.col       = r_tag2.col;
    assign o_result.row       = r_tag2.row;
    assign o_result.frame_end = r_tag2.last;

endmodule
